// File: hw/rtl/slbm_pkg.sv
package slbm_pkg;

  // Program ROM bank limit used by the fixed-last-bank mode
  localparam int MaxPrgBanks = 16;

  // Decoupling queue between front and back
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Control register after reset, and the bits forced by a serial reset
  localparam logic [4:0] CtrlReset    = 5'h0C;
  localparam logic [4:0] CtrlPrgMode3 = 5'h0C;

  // CPU address map
  localparam logic [15:0] PrgRamBase = 16'h6000;
  localparam logic [15:0] MapperBase = 16'h8000;

  // Serial load completes on the fifth bit
  localparam logic [2:0] SerialLastBit = 3'd4;

  typedef enum logic [1:0] {
    CMD_CPU_RD = 2'd0,
    CMD_CPU_WR = 2'd1,
    CMD_PPU_RD = 2'd2,
    CMD_PPU_WR = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    TGT_NONE    = 2'd0,
    TGT_PRG_RAM = 2'd1,
    TGT_PRG_ROM = 2'd2,
    TGT_CHR     = 2'd3
  } target_e;

  typedef enum logic [1:0] {
    ERR_OK        = 2'd0,
    ERR_UNMAPPED  = 2'd1,
    ERR_NO_RAM    = 2'd2,
    ERR_CHR_ROM   = 2'd3
  } error_e;

  typedef enum logic [1:0] {
    CFG_PRG_BANK_COUNT  = 2'd0,
    CFG_PRG_RAM_PRESENT = 2'd1,
    CFG_CHR_WRITABLE    = 2'd2,
    CFG_UNUSED          = 2'd3
  } cfg_idx_e;

  // Access class decided by the front
  typedef enum logic [2:0] {
    CLS_UNMAPPED = 3'd0,
    CLS_RAM_RD   = 3'd1,
    CLS_RAM_WR   = 3'd2,
    CLS_ROM_RD   = 3'd3,
    CLS_SERIAL   = 3'd4,
    CLS_CHR_RD   = 3'd5,
    CLS_CHR_WR   = 3'd6,
    CLS_SPARE    = 3'd7
  } cls_e;

  // Address bits 14-13 select the register: control, CHR low, CHR high, PRG
  typedef enum logic [1:0] {
    REG_CONTROL  = 2'd0,
    REG_CHR_LOW  = 2'd1,
    REG_CHR_HIGH = 2'd2,
    REG_PRG      = 2'd3
  } reg_sel_e;

  typedef struct packed {
    cmd_e        cmd;
    logic [15:0] address;
    logic [7:0]  data;
  } in_word_t;

  typedef struct packed {
    target_e     target;
    logic [17:0] mem_address;
    logic        write_enable;
    logic [7:0]  write_data;
    logic [1:0]  mirroring;
    error_e      error;
  } out_word_t;

  typedef struct packed {
    cls_e        cls;
    logic [15:0] address;
    logic [7:0]  data;
  } q_word_t;

endpackage

// File: hw/rtl/slbm_front.sv
module slbm_front (
  input  slbm_pkg::in_word_t in_word_i,
  output slbm_pkg::q_word_t  q_word_o
);
  import slbm_pkg::*;

  cls_e cls;

  // Classify the access by bus and address window
  always_comb begin
    unique case (in_word_i.cmd)
      CMD_CPU_RD: begin
        if (in_word_i.address < PrgRamBase) begin
          cls = CLS_UNMAPPED;
        end else if (in_word_i.address < MapperBase) begin
          cls = CLS_RAM_RD;
        end else begin
          cls = CLS_ROM_RD;
        end
      end
      CMD_CPU_WR: begin
        if (in_word_i.address < PrgRamBase) begin
          cls = CLS_UNMAPPED;
        end else if (in_word_i.address < MapperBase) begin
          cls = CLS_RAM_WR;
        end else begin
          cls = CLS_SERIAL;
        end
      end
      CMD_PPU_RD: cls = CLS_CHR_RD;
      CMD_PPU_WR: cls = CLS_CHR_WR;
      default:    cls = CLS_UNMAPPED;
    endcase
  end

  assign q_word_o.cls     = cls;
  assign q_word_o.address = in_word_i.address;
  assign q_word_o.data    = in_word_i.data;

endmodule

// File: hw/rtl/slbm_queue.sv
module slbm_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  slbm_pkg::q_word_t push_word_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output slbm_pkg::q_word_t head_word_o,
  output logic [slbm_pkg::QCntW-1:0] count_o
);
  import slbm_pkg::*;

  q_word_t           mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              do_push, do_pop;

  assign do_push = push_i && (count_q != QCntW'(QueueDepth));
  assign do_pop  = pop_i && (count_q != '0);

  // Pointer and fill tracking, wrapping at the depth
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + QPtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + QPtrW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + QCntW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - QCntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Storage, no reset
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_word_i;
    end
  end

  assign full_o       = (count_q == QCntW'(QueueDepth));
  assign head_valid_o = (count_q != '0);
  assign head_word_o  = mem_q[rd_ptr_q];
  assign count_o      = count_q;

endmodule

// File: hw/rtl/slbm_back.sv
module slbm_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  slbm_pkg::cfg_idx_e cfg_index_i,
  input  logic [4:0]         cfg_data_i,
  input  logic               head_valid_i,
  input  slbm_pkg::q_word_t  head_word_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output slbm_pkg::out_word_t out_word_o
);
  import slbm_pkg::*;

  // Configuration registers
  logic [4:0] prg_bank_count_q;
  logic       prg_ram_present_q;
  logic       chr_writable_q;

  // Mapper state
  logic [4:0] shift_q, shift_d;
  logic [2:0] bit_count_q, bit_count_d;
  logic [4:0] ctrl_q, ctrl_d;
  logic [4:0] chr_low_q, chr_low_d;
  logic [4:0] chr_high_q, chr_high_d;
  logic [3:0] prg_bank_q, prg_bank_d;

  // Output register
  logic       out_valid_q;
  out_word_t  out_q, out_d;

  logic        pop;
  logic [4:0]  shift_next;
  logic [4:0]  bank_count_clamped;
  logic [3:0]  prg_last;
  logic [3:0]  prg_sel;
  logic [4:0]  chr_sel;
  logic [17:0] prg_offset;
  logic [17:0] chr_offset;
  logic        prg_upper;
  logic        chr_upper;

  assign pop   = head_valid_i && (!out_valid_q || !out_stall_i);
  assign pop_o = pop;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prg_bank_count_q  <= 5'd2;
      prg_ram_present_q <= 1'b1;
      chr_writable_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_PRG_BANK_COUNT:  prg_bank_count_q  <= cfg_data_i;
        CFG_PRG_RAM_PRESENT: prg_ram_present_q <= cfg_data_i[0];
        CFG_CHR_WRITABLE:    chr_writable_q    <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Program ROM bank: 16KB slots selected by address bit 14
  always_comb begin
    prg_upper = head_word_i.address[14];
    if (prg_bank_count_q == 5'd0) begin
      bank_count_clamped = 5'd1;
    end else if (prg_bank_count_q > 5'(MaxPrgBanks)) begin
      bank_count_clamped = 5'(MaxPrgBanks);
    end else begin
      bank_count_clamped = prg_bank_count_q;
    end
    prg_last = 4'(bank_count_clamped - 5'd1);
    unique case (ctrl_q[3:2])
      2'd0, 2'd1: prg_sel = {prg_bank_q[3:1], prg_upper};
      2'd2:       prg_sel = prg_upper ? prg_bank_q : 4'd0;
      default:    prg_sel = prg_upper ? prg_last : prg_bank_q;
    endcase
    prg_offset = 18'({prg_sel, head_word_i.address[13:0]});
  end

  // Character bank: 4KB slots, upper slot for any address at or above 0x1000
  always_comb begin
    chr_upper = |head_word_i.address[15:12];
    if (ctrl_q[4]) begin
      chr_sel = chr_upper ? chr_high_q : chr_low_q;
    end else begin
      chr_sel = {chr_low_q[4:1], chr_upper};
    end
    chr_offset = 18'({chr_sel, head_word_i.address[11:0]});
  end

  // Carry out the access: state update and result word
  always_comb begin
    shift_d     = shift_q;
    bit_count_d = bit_count_q;
    ctrl_d      = ctrl_q;
    chr_low_d   = chr_low_q;
    chr_high_d  = chr_high_q;
    prg_bank_d  = prg_bank_q;
    shift_next  = {head_word_i.data[0], shift_q[4:1]};

    out_d.target       = TGT_NONE;
    out_d.mem_address  = '0;
    out_d.write_enable = 1'b0;
    out_d.write_data   = '0;
    out_d.error        = ERR_OK;

    unique case (head_word_i.cls)
      CLS_RAM_RD, CLS_RAM_WR: begin
        if (prg_ram_present_q) begin
          out_d.target       = TGT_PRG_RAM;
          out_d.mem_address  = 18'(head_word_i.address[12:0]);
          out_d.write_enable = (head_word_i.cls == CLS_RAM_WR);
          out_d.write_data   = (head_word_i.cls == CLS_RAM_WR) ? head_word_i.data : '0;
        end else begin
          out_d.error = ERR_NO_RAM;
        end
      end
      CLS_ROM_RD: begin
        out_d.target      = TGT_PRG_ROM;
        out_d.mem_address = prg_offset;
      end
      CLS_SERIAL: begin
        if (head_word_i.data[7]) begin
          shift_d     = '0;
          bit_count_d = '0;
          ctrl_d      = ctrl_q | CtrlPrgMode3;
        end else if (bit_count_q == SerialLastBit) begin
          shift_d     = '0;
          bit_count_d = '0;
          unique case (reg_sel_e'(head_word_i.address[14:13]))
            REG_CONTROL:  ctrl_d     = shift_next;
            REG_CHR_LOW:  chr_low_d  = shift_next;
            REG_CHR_HIGH: chr_high_d = shift_next;
            default:      prg_bank_d = shift_next[3:0];
          endcase
        end else begin
          shift_d     = shift_next;
          bit_count_d = bit_count_q + 3'd1;
        end
      end
      CLS_CHR_RD: begin
        out_d.target      = TGT_CHR;
        out_d.mem_address = chr_offset;
      end
      CLS_CHR_WR: begin
        if (chr_writable_q) begin
          out_d.target       = TGT_CHR;
          out_d.mem_address  = chr_offset;
          out_d.write_enable = 1'b1;
          out_d.write_data   = head_word_i.data;
        end else begin
          out_d.error = ERR_CHR_ROM;
        end
      end
      default: begin
        out_d.error = ERR_UNMAPPED;
      end
    endcase

    // Mirroring reflects the control register after this access
    out_d.mirroring = ctrl_d[1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= '0;
      bit_count_q <= '0;
      ctrl_q      <= CtrlReset;
      chr_low_q   <= '0;
      chr_high_q  <= '0;
      prg_bank_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        shift_q     <= shift_d;
        bit_count_q <= bit_count_d;
        ctrl_q      <= ctrl_d;
        chr_low_q   <= chr_low_d;
        chr_high_q  <= chr_high_d;
        prg_bank_q  <= prg_bank_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_word_o  = out_q;

endmodule

// File: hw/rtl/serial_loaded_bank_mapper.sv
// An accepted word is first registered into the queue, then mapped from the queue
// head into the output register; it waits longer while the output is stalled.
// Throughput: one word per cycle unless the output stalls (mapping is combinational).
// The input stalls only while the two-entry queue is full.
// Reset (rst_ni low, asynchronous) empties the queue and output, restores the
// mapper registers (control 0x0C, banks zero) and the configuration defaults.
module serial_loaded_bank_mapper (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_index_i,
  input  logic [4:0]           cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  slbm_pkg::in_word_t   in_word_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output slbm_pkg::out_word_t  out_word_o
);
  import slbm_pkg::*;

  q_word_t          front_word;
  q_word_t          head_word;
  logic             q_full;
  logic             head_valid;
  logic             pop;
  logic [QCntW-1:0] q_count;

  // Front: classify the access
  slbm_front u_front (
    .in_word_i (in_word_i),
    .q_word_o  (front_word)
  );

  // Decoupling queue
  slbm_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (in_valid_i && !q_full),
    .push_word_i  (front_word),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_word_o  (head_word),
    .count_o      (q_count)
  );

  // Back: mapper state and result
  slbm_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_idx_e'(cfg_index_i)),
    .cfg_data_i   (cfg_data_i),
    .head_valid_i (head_valid),
    .head_word_i  (head_word),
    .pop_o        (pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_word_o   (out_word_o)
  );

  assign in_stall_o = q_full;

  // Checks
  a_queue_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_count <= QCntW'(QueueDepth))
    else $error("queue fill beyond depth");

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("pop from empty queue");

  a_err_no_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.error != ERR_OK) |-> (out_word_o.target == TGT_NONE))
    else $error("error word carries a target");

  a_we_has_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_word_o.write_enable) |->
      (out_word_o.target == TGT_PRG_RAM || out_word_o.target == TGT_CHR))
    else $error("write strobe without writable target");

endmodule
